/* hw/rtl/rgtp_pkg.sv */
// shared types and constants for the raster grid test pattern source
// register index codes, configuration struct, colour levels and masks
// no dependencies
package rgtp_pkg;

	// configuration word and pixel coordinate widths
	localparam int CFG_W = 13;
	localparam int PIX_W = 12;
	localparam int NUM_LEVELS = 3;

	typedef logic [CFG_W-1:0] cfg_word_t;
	typedef logic [7:0]       chan_t;
	typedef logic [3:0]       mask_t;

	// register index codes
	typedef enum logic [2:0] {
		REG_PATTERN_MODE     = 3'd0,
		REG_FRAME_WIDTH      = 3'd1,
		REG_FRAME_HEIGHT     = 3'd2,
		REG_FINE_SPACING     = 3'd3,
		REG_MID_SPACING      = 3'd4,
		REG_COARSE_SPACING   = 3'd5,
		REG_CLEAR_BACKGROUND = 3'd6
	} reg_index_t;

	// spacing level slots
	localparam int LVL_FINE   = 0;
	localparam int LVL_MID    = 1;
	localparam int LVL_COARSE = 2;

	// pattern modes
	localparam logic MODE_GRID      = 1'b0;
	localparam logic MODE_CROSSHAIR = 1'b1;

	typedef struct packed {
		logic                       pattern_mode;
		cfg_word_t                  frame_width;
		cfg_word_t                  frame_height;
		cfg_word_t [NUM_LEVELS-1:0] spacing;
		logic                       clear_background;
	} cfg_t;

	// reset values
	localparam cfg_word_t RST_WIDTH  = 13'd512;
	localparam cfg_word_t RST_HEIGHT = 13'd512;
	localparam cfg_word_t RST_FINE   = 13'd10;
	localparam cfg_word_t RST_MID    = 13'd50;
	localparam cfg_word_t RST_COARSE = 13'd100;

	// colour levels
	localparam chan_t COLOR_WHITE = 8'd255;
	localparam chan_t COLOR_GREY  = 8'd128;
	localparam chan_t COLOR_DARK  = 8'd64;
	localparam chan_t COLOR_BLACK = 8'd0;

	// crosshair cell masks
	localparam mask_t MASK_NARROW = 4'h7;
	localparam mask_t MASK_WIDE   = 4'hf;

endpackage

/* hw/rtl/rgtp_cfg_regs.sv */
// configuration register file with clamped frame size and spacing
// depends on rgtp_pkg
module rgtp_cfg_regs #(
	parameter int MAX_DIM = 4096,
	parameter int DW      = 14
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_we,
	input  logic [2:0]                                  cfg_index,
	input  rgtp_pkg::cfg_word_t                         cfg_data,
	output rgtp_pkg::cfg_t                              cfg,
	output logic [DW-1:0]                               width_eff,
	output logic [DW-1:0]                               height_eff,
	output rgtp_pkg::cfg_word_t [rgtp_pkg::NUM_LEVELS-1:0] spacing_eff
);
	import rgtp_pkg::*;

	cfg_t cfg_q;

	function automatic logic [DW-1:0] clamp_dim(cfg_word_t v);
		logic [DW-1:0] ext;
		ext = DW'(v);
		if (v == '0)
			return DW'(1);
		if (32'(ext) > 32'(MAX_DIM))
			return DW'(MAX_DIM);
		return ext;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_mode             <= MODE_GRID;
			cfg_q.frame_width              <= RST_WIDTH;
			cfg_q.frame_height             <= RST_HEIGHT;
			cfg_q.spacing[LVL_FINE]        <= RST_FINE;
			cfg_q.spacing[LVL_MID]         <= RST_MID;
			cfg_q.spacing[LVL_COARSE]      <= RST_COARSE;
			cfg_q.clear_background         <= 1'b0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_PATTERN_MODE:     cfg_q.pattern_mode <= cfg_data[0];
				REG_FRAME_WIDTH:      cfg_q.frame_width <= cfg_data;
				REG_FRAME_HEIGHT:     cfg_q.frame_height <= cfg_data;
				REG_FINE_SPACING:     cfg_q.spacing[LVL_FINE] <= cfg_data;
				REG_MID_SPACING:      cfg_q.spacing[LVL_MID] <= cfg_data;
				REG_COARSE_SPACING:   cfg_q.spacing[LVL_COARSE] <= cfg_data;
				REG_CLEAR_BACKGROUND: cfg_q.clear_background <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg       = cfg_q;
	assign width_eff = clamp_dim(cfg_q.frame_width);
	// crosshair frame is square
	assign height_eff = (cfg_q.pattern_mode == MODE_CROSSHAIR) ? width_eff
		: clamp_dim(cfg_q.frame_height);

	// zero spacing behaves as one
	always_comb begin
		for (int i = 0; i < NUM_LEVELS; i++)
			spacing_eff[i] = (cfg_q.spacing[i] == '0) ? CFG_W'(1) : cfg_q.spacing[i];
	end

endmodule

/* hw/rtl/rgtp_raster.sv */
// raster and phase counters, first pipeline stage
// depends on rgtp_pkg
module rgtp_raster #(
	parameter int CW = 12,
	parameter int DW = 14
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic [DW-1:0]                               width_eff,
	input  logic [DW-1:0]                               height_eff,
	input  rgtp_pkg::cfg_word_t [rgtp_pkg::NUM_LEVELS-1:0] spacing_eff,
	input  logic                                        in_load,
	input  logic                                        frame_start,
	input  logic                                        s1_advance,
	output logic                                        valid_s1,
	output logic [CW-1:0]                               x_s1,
	output logic [CW-1:0]                               y_s1,
	output logic [rgtp_pkg::NUM_LEVELS-1:0]             col_zero_s1,
	output logic [rgtp_pkg::NUM_LEVELS-1:0]             row_zero_s1,
	output logic                                        last_s1
);
	import rgtp_pkg::*;

	logic [CW-1:0]                  col_q, row_q;
	cfg_word_t [NUM_LEVELS-1:0]     col_phase_q, row_phase_q;

	logic [CW-1:0]                  x_cur, y_cur;
	cfg_word_t [NUM_LEVELS-1:0]     col_phase_cur, row_phase_cur;
	cfg_word_t [NUM_LEVELS-1:0]     col_phase_inc, row_phase_inc;
	logic [NUM_LEVELS-1:0]          col_zero, row_zero;
	logic                           row_end, last;

	function automatic cfg_word_t next_phase(cfg_word_t p, cfg_word_t sp);
		logic [CFG_W:0] p1;
		p1 = {1'b0, p} + (CFG_W+1)'(1);
		return (p1 >= {1'b0, sp}) ? '0 : p1[CFG_W-1:0];
	endfunction

	always_comb begin
		x_cur         = frame_start ? '0 : col_q;
		y_cur         = frame_start ? '0 : row_q;
		col_phase_cur = frame_start ? '0 : col_phase_q;
		row_phase_cur = frame_start ? '0 : row_phase_q;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			col_zero[i]      = (col_phase_cur[i] == '0);
			row_zero[i]      = (row_phase_cur[i] == '0);
			col_phase_inc[i] = next_phase(col_phase_cur[i], spacing_eff[i]);
			row_phase_inc[i] = next_phase(row_phase_cur[i], spacing_eff[i]);
		end
		row_end = (DW'(x_cur) + DW'(1)) >= width_eff;
		last    = row_end && ((DW'(y_cur) + DW'(1)) >= height_eff);
	end

	// counter state moves on every accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			col_phase_q <= '0;
			row_phase_q <= '0;
		end else if (in_load) begin
			if (row_end) begin
				col_q       <= '0;
				col_phase_q <= '0;
				if (last) begin
					row_q       <= '0;
					row_phase_q <= '0;
				end else begin
					row_q       <= y_cur + CW'(1);
					row_phase_q <= row_phase_inc;
				end
			end else begin
				col_q       <= x_cur + CW'(1);
				col_phase_q <= col_phase_inc;
				row_q       <= y_cur;
				row_phase_q <= row_phase_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_load)
			valid_s1 <= 1'b1;
		else if (s1_advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_load) begin
			x_s1        <= x_cur;
			y_s1        <= y_cur;
			col_zero_s1 <= col_zero;
			row_zero_s1 <= row_zero;
			last_s1     <= last;
		end
	end

endmodule

/* hw/rtl/rgtp_shade.sv */
// pixel colour logic and result register
// depends on rgtp_pkg
module rgtp_shade #(
	parameter int CW         = 12,
	parameter int DW         = 14,
	parameter int WIDE_LIMIT = 512
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rgtp_pkg::cfg_t                  cfg,
	input  logic [DW-1:0]                   width_eff,
	input  logic                            out_advance,
	input  logic                            valid_s1,
	input  logic [CW-1:0]                   x_s1,
	input  logic [CW-1:0]                   y_s1,
	input  logic [rgtp_pkg::NUM_LEVELS-1:0] col_zero_s1,
	input  logic [rgtp_pkg::NUM_LEVELS-1:0] row_zero_s1,
	input  logic                            last_s1,
	output logic                            valid_s2,
	output logic [rgtp_pkg::PIX_W-1:0]      x_s2,
	output logic [rgtp_pkg::PIX_W-1:0]      y_s2,
	output rgtp_pkg::chan_t                 red_s2,
	output rgtp_pkg::chan_t                 green_s2,
	output rgtp_pkg::chan_t                 blue_s2,
	output logic                            paint_s2,
	output logic                            last_s2
);
	import rgtp_pkg::*;

	localparam int XW = (CW > PIX_W) ? CW : PIX_W;

	logic [XW-1:0]  x_ext, y_ext;
	logic [DW-1:0]  xd, yd, mid;
	mask_t          mask;
	logic           on_diag, on_mid, in_cell;
	logic [NUM_LEVELS-1:0] on_line;
	chan_t          level, red, gb;
	logic           paint;

	always_comb begin
		x_ext   = XW'(x_s1);
		y_ext   = XW'(y_s1);
		xd      = DW'(x_s1);
		yd      = DW'(y_s1);
		mid     = width_eff >> 1;
		mask    = (32'(width_eff) <= 32'(WIDE_LIMIT)) ? MASK_NARROW : MASK_WIDE;
		on_diag = (xd == yd) || ((yd <= width_eff) && (xd == (width_eff - yd)));
		on_mid  = (xd == mid) || (yd == mid);
		in_cell = ((x_s1[3:0] & mask) != '0) && ((y_s1[3:0] & mask) != '0);
		on_line = col_zero_s1 | row_zero_s1;

		// coarse lines win over mid, mid over fine
		if (on_line[LVL_COARSE])
			level = COLOR_WHITE;
		else if (on_line[LVL_MID])
			level = COLOR_GREY;
		else if (on_line[LVL_FINE])
			level = COLOR_DARK;
		else
			level = COLOR_BLACK;

		if (cfg.pattern_mode == MODE_GRID) begin
			red   = level;
			gb    = level;
			paint = (level != COLOR_BLACK) || cfg.clear_background;
		end else begin
			paint = 1'b1;
			if (on_diag) begin
				red = COLOR_WHITE;
				gb  = COLOR_WHITE;
			end else if (on_mid) begin
				red = COLOR_WHITE;
				gb  = COLOR_BLACK;
			end else if (in_cell) begin
				red = COLOR_BLACK;
				gb  = COLOR_BLACK;
			end else begin
				red = COLOR_WHITE;
				gb  = COLOR_WHITE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (out_advance)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (out_advance && valid_s1) begin
			x_s2     <= x_ext[PIX_W-1:0];
			y_s2     <= y_ext[PIX_W-1:0];
			red_s2   <= red;
			green_s2 <= gb;
			blue_s2  <= gb;
			paint_s2 <= paint;
			last_s2  <= last_s1;
		end
	end

endmodule

/* hw/rtl/raster_grid_test_pattern.sv */
// top level of the raster grid test pattern source
// depends on rgtp_pkg, rgtp_cfg_regs, rgtp_raster, rgtp_shade
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   in       | in_valid / in_stall  | frame_start
//   out      | out_valid / out_stall| pixel_x pixel_y pixel_red/green/blue paint frame_end
//   cfg      | cfg_we               | cfg_index cfg_data
//
// one pixel request per clock sustained while out_stall is low; each request passes
// through the raster stage register and then the result register
// async reset clears counters, valids and configuration registers to their power-on values
// a stalled result holds in the result register while the raster stage still
// takes one more request; input stalls only when both stages are full
module raster_grid_test_pattern #(
	parameter int MAX_DIM    = 4096,
	parameter int WIDE_LIMIT = 512
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration writes
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  rgtp_pkg::cfg_word_t        cfg_data,
	// pixel tick requests
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       frame_start,
	// pixel results
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [rgtp_pkg::PIX_W-1:0] pixel_x,
	output logic [rgtp_pkg::PIX_W-1:0] pixel_y,
	output rgtp_pkg::chan_t            pixel_red,
	output rgtp_pkg::chan_t            pixel_green,
	output rgtp_pkg::chan_t            pixel_blue,
	output logic                       paint,
	output logic                       frame_end
);
	import rgtp_pkg::*;

	// counter width covers coordinates up to MAX_DIM - 1
	localparam int CW = $clog2(MAX_DIM);
	// size compares need room for the raw 13 bit register and MAX_DIM itself
	localparam int DW = (CW + 1 > CFG_W + 1) ? CW + 1 : CFG_W + 1;

	cfg_t                       cfg;
	logic [DW-1:0]              width_eff, height_eff;
	cfg_word_t [NUM_LEVELS-1:0] spacing_eff;

	logic                       valid_s1, last_s1;
	logic [CW-1:0]              x_s1, y_s1;
	logic [NUM_LEVELS-1:0]      col_zero_s1, row_zero_s1;

	logic                       out_advance, in_load;

	// result register frees up when empty or when its request leaves
	assign out_advance = !out_valid || !out_stall;
	// raster stage blocks only while full and its successor is held
	assign in_stall    = valid_s1 && !out_advance;
	assign in_load     = in_valid && !in_stall;

	rgtp_cfg_regs #(
		.MAX_DIM (MAX_DIM),
		.DW      (DW)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cfg         (cfg),
		.width_eff   (width_eff),
		.height_eff  (height_eff),
		.spacing_eff (spacing_eff)
	);

	// raster walk, phase tracking, stage one register
	rgtp_raster #(
		.CW (CW),
		.DW (DW)
	) u_raster (
		.clk         (clk),
		.arst_n      (arst_n),
		.width_eff   (width_eff),
		.height_eff  (height_eff),
		.spacing_eff (spacing_eff),
		.in_load     (in_load),
		.frame_start (frame_start),
		.s1_advance  (out_advance),
		.valid_s1    (valid_s1),
		.x_s1        (x_s1),
		.y_s1        (y_s1),
		.col_zero_s1 (col_zero_s1),
		.row_zero_s1 (row_zero_s1),
		.last_s1     (last_s1)
	);

	// colour pick and result register
	rgtp_shade #(
		.CW         (CW),
		.DW         (DW),
		.WIDE_LIMIT (WIDE_LIMIT)
	) u_shade (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.width_eff   (width_eff),
		.out_advance (out_advance),
		.valid_s1    (valid_s1),
		.x_s1        (x_s1),
		.y_s1        (y_s1),
		.col_zero_s1 (col_zero_s1),
		.row_zero_s1 (row_zero_s1),
		.last_s1     (last_s1),
		.valid_s2    (out_valid),
		.x_s2        (pixel_x),
		.y_s2        (pixel_y),
		.red_s2      (pixel_red),
		.green_s2    (pixel_green),
		.blue_s2     (pixel_blue),
		.paint_s2    (paint),
		.last_s2     (frame_end)
	);

endmodule

/* hw/rtl/rgtp_checker.sv */
// port level checks for the raster grid test pattern source
// depends on rgtp_pkg; bound to raster_grid_test_pattern
module rgtp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [rgtp_pkg::PIX_W-1:0] pixel_x,
	input logic [rgtp_pkg::PIX_W-1:0] pixel_y,
	input rgtp_pkg::chan_t            pixel_red,
	input rgtp_pkg::chan_t            pixel_green,
	input rgtp_pkg::chan_t            pixel_blue,
	input logic                       paint
);
	import rgtp_pkg::*;

	// input backs up only behind a held result
	a_stall_needs_held_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while result side was free");

	// unpainted pixels carry zero colour
	a_unpainted_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !paint) |->
			(pixel_red == COLOR_BLACK && pixel_green == COLOR_BLACK
				&& pixel_blue == COLOR_BLACK))
		else $error("unpainted pixel with nonzero colour");

	// no pattern produces green different from blue
	a_green_blue_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_green == pixel_blue))
		else $error("green and blue differ");

	// held result stays put: coordinates and red channel are checked
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_red)))
		else $error("stalled result changed");

endmodule

bind raster_grid_test_pattern rgtp_checker u_rgtp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pixel_x     (pixel_x),
	.pixel_y     (pixel_y),
	.pixel_red   (pixel_red),
	.pixel_green (pixel_green),
	.pixel_blue  (pixel_blue),
	.paint       (paint)
);
